### hdl/target_track_table_top_defines.svh
// Assertion macros for the target track table.
`ifndef TARGET_TRACK_TABLE_TOP_DEFINES_SVH
`define TARGET_TRACK_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TTT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTT_ASSERT(lbl, clk, rstn, prop, msg)
`define TTT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/ttt_pkg.sv
// Shared types and constants of the target track table.
package ttt_pkg;
    localparam int MAX_TARGETS_DEF = 64;
    localparam int ID_W = 8;
    localparam int CNT_W = 9;
    localparam int TC_W = 7;
    localparam int DELTA_W = 20;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 53;
    localparam int MAG_W = 52;
    localparam logic signed [20:0] US_PER_S = 21'sd1000000;
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             is_query;
        logic             in_range;
        logic [ID_W-1:0]  id;
        logic [31:0]      pos_x;
        logic [31:0]      pos_y;
        logic [31:0]      time_us;
    } cmd_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] last_t;
    } ent_t;

    typedef enum logic [2:0] {
        B_IDLE, B_EVAL, B_DIV
    } back_state_t;

    typedef enum logic [2:0] {
        D_IDLE, D_MUL, D_ABS, D_ITER, D_DONE
    } div_state_t;
endpackage

### hdl/ttt_front.sv
// Front end: accepts items, drops out-of-range updates, queues the rest.
module ttt_front import ttt_pkg::*; #(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // target_id, pos_x, pos_y, time_us
    input  logic         s_tuser,  // action
    output logic         q_valid,
    input  logic         q_pop,
    output cmd_t         q_head
);
    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd;
    logic       push;

    always_comb begin
        cmd.is_query = (s_tuser == ACT_QUERY);
        cmd.id       = s_tdata[7:0];
        cmd.pos_x    = s_tdata[39:8];
        cmd.pos_y    = s_tdata[71:40];
        cmd.time_us  = s_tdata[103:72];
        cmd.in_range = ({1'b0, s_tdata[7:0]} < CNT_W'(MAX_TARGETS));
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready && (cmd.is_query || cmd.in_range);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd;
        end
    end
endmodule

### hdl/ttt_div.sv
// Velocity unit: scales a position change to per second, divides bit-serially, saturates.
module ttt_div import ttt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] diff,
    input  logic [31:0]              dt,
    output logic                     done,
    output logic [31:0]              vel
);
    div_state_t               state_reg, state_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [31:0]              den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         quo_reg;
    logic [32:0]              rem_reg;
    logic [5:0]               step_reg;
    logic [32:0]              rem_sh;
    logic                     fits;

    assign rem_sh = {rem_reg[31:0], quo_reg[MAG_W-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_MUL;
            D_MUL:  state_next = D_ABS;
            D_ABS:  state_next = D_ITER;
            D_ITER: if (step_reg == 6'(MAG_W - 1)) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == D_DONE);
        if (neg_reg) begin
            vel = (quo_reg > MAG_W'(33'h80000000)) ? 32'h80000000
                                                   : (~quo_reg[31:0] + 32'd1);
        end else begin
            vel = (quo_reg > MAG_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                diff_reg <= diff;
                den_reg  <= dt;
            end
            D_MUL: begin
                prod_reg <= PROD_W'(diff_reg * US_PER_S);
            end
            D_ABS: begin
                neg_reg  <= prod_reg[PROD_W-1];
                quo_reg  <= prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
                rem_reg  <= 33'd0;
                step_reg <= 6'd0;
            end
            D_ITER: begin
                rem_reg  <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg  <= {quo_reg[MAG_W-2:0], fits};
                step_reg <= step_reg + 6'd1;
            end
            D_DONE: begin
            end
            default: begin
            end
        endcase
    end
endmodule

### hdl/ttt_back.sv
// Back end: entry store, known flags, velocity update and query results.
module ttt_back import ttt_pkg::*; #(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  cmd_t               q_head,
    input  logic [TC_W-1:0]    expected_count,
    input  logic [DELTA_W-1:0] min_delta_us,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [135:0]       m_tdata,  // rep_pos_x, rep_pos_y, rep_vel_x, rep_vel_y, target_count
    output logic               m_tuser   // known
);
`include "target_track_table_top_defines.svh"
    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

    ent_t             mem [MAX_TARGETS];
    ent_t             rd_reg;
    ent_t             wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg;
    logic [MAX_TARGETS-1:0] known_reg;
    logic [CNT_W-1:0] seen_reg;
    logic             out_valid_reg;
    logic [135:0]     out_data_reg;
    logic             out_known_reg;

    logic             known_hit;
    logic [31:0]      dt;
    logic             vel_ok;
    logic             out_load;
    logic             div_start;
    logic             done_x, done_y;
    logic [31:0]      vel_x, vel_y;
    logic [CNT_W-1:0] cnt_max;
    logic [CNT_W-1:0] cnt_lim;
    logic [CNT_W-1:0] seen_new;

    assign rd_addr   = q_head.id[IDX_W-1:0];
    assign wr_addr   = cmd_reg.id[IDX_W-1:0];
    assign known_hit = cmd_reg.in_range && known_reg[wr_addr];
    assign dt        = cmd_reg.time_us - rd_reg.last_t;
    assign vel_ok    = known_hit && ($signed(dt) > $signed({12'd0, min_delta_us}));
    assign seen_new  = CNT_W'(cmd_reg.id) + CNT_W'(1);

    always_comb begin
        cnt_max = (CNT_W'(expected_count) > seen_reg) ? CNT_W'(expected_count) : seen_reg;
        cnt_lim = (cnt_max > CNT_W'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS) : cnt_max;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (q_valid) state_next = B_EVAL;
            B_EVAL: begin
                if (cmd_reg.is_query) begin
                    if (!out_valid_reg || m_tready) state_next = B_IDLE;
                end else if (vel_ok) begin
                    state_next = B_DIV;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_DIV: if (done_x) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        wr_data   = '{cmd_reg.pos_x, cmd_reg.pos_y, 32'd0, 32'd0, cmd_reg.time_us};
        unique case (state_reg)
            B_IDLE: q_pop = q_valid;
            B_EVAL: begin
                if (cmd_reg.is_query) begin
                    out_load = !out_valid_reg || m_tready;
                end else if (vel_ok) begin
                    div_start = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    if (known_hit) begin
                        wr_data.vel_x = rd_reg.vel_x;
                        wr_data.vel_y = rd_reg.vel_y;
                    end
                end
            end
            B_DIV: begin
                wr_en = done_x;
                wr_data.vel_x = vel_x;
                wr_data.vel_y = vel_y;
            end
            default: begin
            end
        endcase
    end

    ttt_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .diff    ($signed({cmd_reg.pos_x[31], cmd_reg.pos_x})
                  - $signed({rd_reg.pos_x[31], rd_reg.pos_x})),
        .dt      (dt),
        .done    (done_x),
        .vel     (vel_x)
    );

    ttt_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .diff    ($signed({cmd_reg.pos_y[31], cmd_reg.pos_y})
                  - $signed({rd_reg.pos_y[31], rd_reg.pos_y})),
        .dt      (dt),
        .done    (done_y),
        .vel     (vel_y)
    );

    // entry is held from pop until the item is finished
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (q_pop) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            known_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                known_reg[wr_addr] <= 1'b1;
                if (seen_new > seen_reg) seen_reg <= seen_new;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        if (out_load) begin
            out_known_reg <= known_hit;
            // unknown and out-of-range entries report zero
            out_data_reg  <= known_hit
                ? {1'b0, cnt_lim[TC_W-1:0], rd_reg.vel_y, rd_reg.vel_x, rd_reg.pos_y, rd_reg.pos_x}
                : {1'b0, cnt_lim[TC_W-1:0], 128'd0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_known_reg;

    `TTT_ASSERT(a_div_lockstep, aclk, aresetn, done_x == done_y, "velocity units out of step")
    `TTT_ASSERT(a_done_in_div, aclk, aresetn, done_x |-> state_reg == B_DIV, "stray divide done")
    `TTT_ASSERT(a_write_sets_known, aclk, aresetn, wr_en |=> known_reg[$past(wr_addr)],
                "written entry not marked known")
    `TTT_ASSERT(a_seen_monotonic, aclk, aresetn, ##1 seen_reg >= $past(seen_reg),
                "seen count decreased")
    `TTT_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (known_reg == '0 && !out_valid_reg),
                       "reset did not clear table state")
endmodule

### hdl/target_track_table_top.sv
// Top level of the target track table: APB registers, front end and back end.
// Target track table. Updates (tuser 0) store position and timestamp for an id below
// MAX_TARGETS and, when the entry is known and the signed time step exceeds
// min_delta_us, replace its velocity by the position change per second; a query
// (tuser 1) returns one item with the entry and the table count. Updates out of range
// are dropped. A query or an update that keeps its velocity passes through the back
// end's pop and evaluate states, plus any wait for the result register; an update that
// recomputes velocity steps through pop, evaluate and the two bit-serial dividers (one
// multiply, one magnitude, 52 restoring steps, one result).
// A two-item queue lets the input side keep accepting while the back end works, and
// a result register lets the next update proceed while a result waits to be taken.
module target_track_table_top import ttt_pkg::*; #(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // target_id, pos_x, pos_y, time_us
    input  logic         s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // rep_pos_x, rep_pos_y, rep_vel_x, rep_vel_y, target_count
    output logic         m_tuser,  // known
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam logic REG_EXPECTED = 1'b0;
    localparam logic REG_MIN_DELTA = 1'b1;

    logic [TC_W-1:0]    expected_reg;
    logic [DELTA_W-1:0] min_delta_reg;
    logic               q_valid;
    logic               q_pop;
    cmd_t               q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DELTA) ? {12'd0, min_delta_reg}
                                                : {25'd0, expected_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg  <= '0;
            min_delta_reg <= DELTA_W'(1000);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_EXPECTED) begin
                expected_reg <= pwdata[TC_W-1:0];
            end else begin
                min_delta_reg <= pwdata[DELTA_W-1:0];
            end
        end
    end

    ttt_front #(.MAX_TARGETS(MAX_TARGETS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    ttt_back #(.MAX_TARGETS(MAX_TARGETS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_head         (q_head),
        .expected_count (expected_reg),
        .min_delta_us   (min_delta_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );
endmodule

### tb/sv/target_track_table_top_tb.sv
// Self-checking testbench for the target track table: random updates and queries.
`timescale 1ns / 1ps

module target_track_table_top_tb;
    import ttt_pkg::*;

    localparam int N_TGT = 64;
    localparam logic [2:0] ADDR_EXP_CNT = 3'd0;
    localparam logic [2:0] ADDR_MIN_DELTA = 3'd4;

    typedef struct packed {
        logic        known;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [6:0]  count;
    } report_t;

    // Track table predictor plus queue of pending query reports
    class track_scoreboard;
        bit          known_q[N_TGT];
        logic [31:0] px[N_TGT], py[N_TGT], vx[N_TGT], vy[N_TGT], tlast[N_TGT];
        int unsigned seen_cnt;
        int unsigned exp_cnt;
        int unsigned min_delta;
        report_t     pending[$];
        int          errors;

        function new();
            for (int i = 0; i < N_TGT; i++) begin
                known_q[i] = 0; px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; tlast[i] = 0;
            end
            seen_cnt = 0; exp_cnt = 0; min_delta = 1000; errors = 0;
        endfunction

        function logic [31:0] rate(logic [31:0] p_new, logic [31:0] p_old, longint dt);
            longint num, q;
            num = (longint'($signed(p_new)) - longint'($signed(p_old))) * 64'sd1000000;
            q = num / dt;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            return q[31:0];
        endfunction

        function void note_item(logic act, logic [7:0] id, logic [31:0] x, logic [31:0] y,
                                logic [31:0] t);
            report_t r;
            longint dt;
            int unsigned c;
            logic [31:0] d;
            if (act == ACT_UPDATE) begin
                if (id >= N_TGT) return;
                if (known_q[id]) begin
                    d = t - tlast[id];
                    dt = longint'($signed(d));
                    if (dt > longint'(min_delta)) begin
                        vx[id] = rate(x, px[id], dt);
                        vy[id] = rate(y, py[id], dt);
                    end
                end else begin
                    vx[id] = 0; vy[id] = 0;
                end
                px[id] = x; py[id] = y; tlast[id] = t; known_q[id] = 1;
                if (id + 1 > seen_cnt) seen_cnt = id + 1;
                return;
            end
            c = exp_cnt > seen_cnt ? exp_cnt : seen_cnt;
            if (c > N_TGT) c = N_TGT;
            r = '0;
            if (id < N_TGT) begin
                r.known = known_q[id]; r.pos_x = px[id]; r.pos_y = py[id];
                r.vel_x = vx[id]; r.vel_y = vy[id];
            end
            r.count = c[6:0];
            pending.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected report %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display("report mismatch: exp known=%0d px=%h py=%h vx=%h vy=%h cnt=%0d / got known=%0d px=%h py=%h vx=%h vy=%h cnt=%0d",
                             e.known, e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.count,
                             got.known, got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                             got.count);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;  // target_id, pos_x, pos_y, time_us
    logic         s_tuser = 0;   // action
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;       // rep_pos_x, rep_pos_y, rep_vel_x, rep_vel_y, target_count
    logic         m_tuser;       // known
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    track_scoreboard sb = new();
    bit   no_idle = 0;
    logic [31:0] clock_us[N_TGT];

    target_track_table_top dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Result side: random stall bursts, none at the end
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_report({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                 m_tdata[127:96], m_tdata[134:128]});
            end
            if (n > 0) begin
                n--;
                m_tready <= 0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 19) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic reg_write(logic [2:0] a, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == ADDR_EXP_CNT) sb.exp_cnt = v & 32'h7F;
        else sb.min_delta = v & 32'hFFFFF;
    endtask

    // tvalid stays high across back-to-back items; it drops only for idle gaps and in drain
    task automatic send_item(logic act, logic [7:0] id, logic [31:0] x, logic [31:0] y,
                             logic [31:0] t);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {t, y, x, id};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(act, id, x, y, t);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        // up to three velocity updates may still be in flight
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // Well-formed track: mostly ids in range, times stepping forward
    task automatic random_item();
        logic [7:0] id;
        logic [31:0] t;
        id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, N_TGT - 1);
        if ($urandom_range(0, 2) == 0) begin
            send_item(ACT_QUERY, id, $urandom, $urandom, $urandom);
        end else begin
            case ($urandom_range(0, 5))
                0: t = $urandom;
                1: t = clock_us[id[5:0]] - $urandom_range(0, 5000);
                default: t = clock_us[id[5:0]] + $urandom_range(0, 300000);
            endcase
            clock_us[id[5:0]] = t;
            send_item(ACT_UPDATE, id, rand_pos(), rand_pos(), t);
        end
    endtask

    initial begin
        foreach (clock_us[i]) clock_us[i] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table, ranges, time step edge cases
        send_item(ACT_QUERY, 8'd0, '0, '0, '0);
        send_item(ACT_QUERY, 8'd255, '1, '1, '1);
        send_item(ACT_UPDATE, 8'd255, 32'h1234, 32'h5678, 32'd5);
        send_item(ACT_QUERY, 8'd63, '0, '0, '0);
        send_item(ACT_UPDATE, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_item(ACT_UPDATE, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1001);
        send_item(ACT_QUERY, 8'd0, '0, '0, '0);
        send_item(ACT_UPDATE, 8'd0, 32'h0001_0000, 32'h0, 32'd2001);
        send_item(ACT_UPDATE, 8'd0, 32'h0002_0000, 32'h0, 32'd2001);
        send_item(ACT_UPDATE, 8'd0, 32'h0003_0000, 32'h0, 32'd1000);
        send_item(ACT_QUERY, 8'd0, '0, '0, '0);
        send_item(ACT_UPDATE, 8'd63, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFF0);
        send_item(ACT_UPDATE, 8'd63, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_1000);
        send_item(ACT_QUERY, 8'd63, '0, '0, '0);
        send_item(ACT_QUERY, 8'd64, '0, '0, '0);
        drain();
        reg_write(ADDR_EXP_CNT, 32'd127);
        reg_write(ADDR_MIN_DELTA, 32'd0);
        send_item(ACT_UPDATE, 8'd5, 32'd100, 32'd200, 32'd10);
        send_item(ACT_UPDATE, 8'd5, 32'd300, 32'd100, 32'd11);
        send_item(ACT_QUERY, 8'd5, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(ADDR_EXP_CNT, 32'd64); reg_write(ADDR_MIN_DELTA, 32'hFFFFF); end
                1: begin reg_write(ADDR_EXP_CNT, 32'd0); reg_write(ADDR_MIN_DELTA, 32'd1000); end
                2: begin reg_write(ADDR_EXP_CNT, $urandom_range(0, 127));
                         reg_write(ADDR_MIN_DELTA, $urandom); end
                3: begin reg_write(ADDR_EXP_CNT, 32'd65); reg_write(ADDR_MIN_DELTA, 32'd1000000); end
                default: begin reg_write(ADDR_EXP_CNT, $urandom_range(0, 64));
                               reg_write(ADDR_MIN_DELTA, $urandom_range(0, 20000)); end
            endcase
            if (ph == 5) no_idle = 1;
            repeat (72) random_item();
            drain();  // sender holds off until all reports are in
        end

        if (sb.errors == 0)
            $display("target_track_table_top: match");
        else
            $display("target_track_table_top: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("target_track_table_top: mismatch");
        $finish;
    end
endmodule

### target_track_table_top.f
+incdir+hdl
hdl/ttt_pkg.sv
hdl/ttt_front.sv
hdl/ttt_div.sv
hdl/ttt_back.sv
hdl/target_track_table_top.sv
tb/sv/target_track_table_top_tb.sv
